@@ rtl/bvss_pkg.sv @@
// Shared constants, opcodes and field widths for the bounded vector store.
package bvss_pkg;

  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = 6;
  localparam int LEN_W    = 7;
  localparam int OP_W     = 3;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_RESIZE = 3'd3;
  localparam logic [OP_W-1:0] OP_SORT   = 3'd4;

endpackage

@@ rtl/bvss_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module bvss_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bvss_cmp.sv @@
// Less-than unit for the sort scan, signed or unsigned by register.
module bvss_cmp
  import bvss_pkg::*;
(
  input  logic [ELEM_W-1:0] a_i,
  input  logic [ELEM_W-1:0] b_i,
  input  logic              signed_i,
  output logic              lt_o
);

  logic [ELEM_W-1:0] a_adj;
  logic [ELEM_W-1:0] b_adj;

  // flip the sign bit in signed mode so one unsigned compare serves both modes
  always_comb begin
    a_adj = a_i;
    b_adj = b_i;
    a_adj[ELEM_W-1] = a_i[ELEM_W-1] ^ signed_i;
    b_adj[ELEM_W-1] = b_i[ELEM_W-1] ^ signed_i;
  end

  assign lt_o = a_adj < b_adj;

endmodule

@@ rtl/bounded_vector_with_selection_sort_unit.sv @@
// Push, set, resize and refused items give their result in the cycle after accept; get
// reads the RAM through S_GET; sort of n >= 2 elements runs passes i = 0..n-2, each via
// S_PASS, S_SCAN over elements i..n-1 and S_SWAP1, plus an S_SWAP2 write when it swaps,
// bound by the one RAM read port that the scan steps through. One item at a time: no new
// item while busy or while a result waits. Reset clears length, mode and control; the store
// reads as zero through per-entry valid flops, so no clearing pass is needed.
module bounded_vector_with_selection_sort_unit
  import bvss_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: opcode[2:0], element_index[8:3], element_value[40:9], length_request[47:41]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: success[0], read_value[32:1], used_length[39:33]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GET   = 3'd1;
  localparam logic [2:0] S_PASS  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SWAP1 = 3'd4;
  localparam logic [2:0] S_SWAP2 = 3'd5;

  logic [OP_W-1:0]   opcode;
  logic [IDX_W-1:0]  element_index;
  logic [ELEM_W-1:0] element_value;
  logic [LEN_W-1:0]  length_request;

  assign opcode         = s_axis_tdata_i[2:0];
  assign element_index  = s_axis_tdata_i[8:3];
  assign element_value  = s_axis_tdata_i[40:9];
  assign length_request = s_axis_tdata_i[47:41];

  logic [2:0]        state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              sgn_q;
  logic [LEN_W-1:0]  i_q, i_d;
  logic [LEN_W-1:0]  p_q, p_d;
  logic [LEN_W-1:0]  m_q, m_d;
  logic [ELEM_W-1:0] min_q, min_d;
  logic [ELEM_W-1:0] ival_q, ival_d;
  logic [CAPACITY-1:0] valid_q;
  logic              rd_valid_q;

  logic              out_valid_q;
  logic              out_ok_q;
  logic [ELEM_W-1:0] out_rd_q;
  logic [LEN_W-1:0]  out_len_q;

  logic              out_load;
  logic              out_ok_v;
  logic [ELEM_W-1:0] out_rd_v;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [ELEM_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;
  logic [ELEM_W-1:0] ram_rdata;
  logic [ELEM_W-1:0] rdata;
  logic              lt;
  logic              accept;
  logic [LEN_W-1:0]  i_next;
  logic [LEN_W-1:0]  last_idx;

  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // entries never written read as zero
  assign rdata    = rd_valid_q ? ram_rdata : '0;
  assign i_next   = i_q + LEN_W'(1);
  assign last_idx = len_q - LEN_W'(1);

  bvss_ram #(
    .Width (ELEM_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  bvss_cmp u_cmp (
    .a_i      (rdata),
    .b_i      (min_q),
    .signed_i (sgn_q),
    .lt_o     (lt)
  );

  function automatic logic [IDX_W-1:0] p_next_addr(input logic [LEN_W-1:0] p);
    logic [LEN_W-1:0] n;
    n = p + LEN_W'(1);
    return n[IDX_W-1:0];
  endfunction

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    i_d      = i_q;
    p_d      = p_q;
    m_d      = m_q;
    min_d    = min_q;
    ival_d   = ival_q;
    we       = 1'b0;
    waddr    = element_index;
    wdata    = element_value;
    raddr    = element_index;
    out_load = 1'b0;
    out_ok_v = 1'b0;
    out_rd_v = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_PUSH: begin
              out_load = 1'b1;
              if (len_q < LEN_W'(CAPACITY)) begin
                we       = 1'b1;
                waddr    = len_q[IDX_W-1:0];
                len_d    = len_q + LEN_W'(1);
                out_ok_v = 1'b1;
              end
            end
            OP_SET: begin
              out_load = 1'b1;
              if ({1'b0, element_index} < len_q) begin
                we       = 1'b1;
                out_ok_v = 1'b1;
              end
            end
            OP_GET: begin
              if ({1'b0, element_index} < len_q) begin
                state_d = S_GET;
              end else begin
                out_load = 1'b1;
              end
            end
            OP_RESIZE: begin
              out_load = 1'b1;
              if (length_request != '0 && length_request <= LEN_W'(CAPACITY)) begin
                len_d    = length_request;
                out_ok_v = 1'b1;
              end
            end
            OP_SORT: begin
              if (len_q < LEN_W'(2)) begin
                out_load = 1'b1;
                out_ok_v = 1'b1;
              end else begin
                i_d     = '0;
                state_d = S_PASS;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_GET: begin
        out_load = 1'b1;
        out_ok_v = 1'b1;
        out_rd_v = rdata;
        state_d  = S_IDLE;
      end
      S_PASS: begin
        raddr   = i_q[IDX_W-1:0];
        p_d     = i_q;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // read one ahead while comparing the element at p
        raddr = p_next_addr(p_q);
        if (p_q == i_q) begin
          ival_d = rdata;
          min_d  = rdata;
          m_d    = i_q;
        end else if (lt) begin
          min_d = rdata;
          m_d   = p_q;
        end
        if (p_q == last_idx) begin
          state_d = S_SWAP1;
        end else begin
          p_d = p_q + LEN_W'(1);
        end
      end
      S_SWAP1: begin
        if (m_q != i_q) begin
          we      = 1'b1;
          waddr   = i_q[IDX_W-1:0];
          wdata   = min_q;
          state_d = S_SWAP2;
        end else begin
          i_d = i_next;
          if (i_next == last_idx) begin
            out_load = 1'b1;
            out_ok_v = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_PASS;
          end
        end
      end
      S_SWAP2: begin
        we    = 1'b1;
        waddr = m_q[IDX_W-1:0];
        wdata = ival_q;
        i_d   = i_next;
        if (i_next == last_idx) begin
          out_load = 1'b1;
          out_ok_v = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_PASS;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      sgn_q       <= 1'b0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      p_q         <= '0;
      m_q         <= '0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      i_q        <= i_d;
      p_q        <= p_d;
      m_q        <= m_d;
      rd_valid_q <= valid_q[raddr];
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cfg_valid_i) begin
        sgn_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    min_q  <= min_d;
    ival_q <= ival_d;
    if (out_load) begin
      out_ok_q  <= out_ok_v;
      out_rd_q  <= out_rd_v;
      out_len_q <= len_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_len_q, out_rd_q, out_ok_q};

endmodule

@@ rtl/bvss_chk.sv @@
// Port-level checker for the bounded vector store, bound to the top level.
module bvss_chk
  import bvss_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_no_accept_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("item taken while result waits");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[39:33] <= LEN_W'(CAPACITY))
    else $error("used length above capacity");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[32:1] == '0)
    else $error("refused item returned data");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write not taken");

endmodule

bind bounded_vector_with_selection_sort_unit bvss_chk u_bvss_chk (.*);

@@ test/tb_top.sv @@
// Testbench for the bounded vector store: random and directed commands, checked result by result.
`timescale 1ns / 1ps

module tb_top
  import bvss_pkg::*;
();

  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
  localparam int IDLE_PCT    = 20;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [LEN_W-1:0]  len_req;
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic [OP_W-1:0]   opcode;
  } vec_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0]  used_length;
    logic [ELEM_W-1:0] read_value;
    logic              success;
  } vec_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // tdata: opcode[2:0], element_index[8:3], element_value[40:9], length_request[47:41]
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // tdata: success[0], read_value[32:1], used_length[39:33]
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i = 1'b0;

  bounded_vector_with_selection_sort_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Shadow copy of the block state
  logic [ELEM_W-1:0] shadow_store [CAPACITY];
  logic [LEN_W-1:0]  shadow_len;
  logic              compare_signed_q;

  vec_cmd_t    pending_cmds[$];
  vec_result_t expected_results[$];
  vec_cmd_t    offer_cmd;
  bit          offer_taken;
  int          cmds_accepted;
  int          results_checked;
  int          failures;
  int          hold_left;
  bit          hold_done;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit elem_less(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
    if (compare_signed_q) return $signed(a) < $signed(b);
    return a < b;
  endfunction

  // Selection sort, strict less-than, first minimum kept
  function automatic void sort_shadow();
    int n;
    int m;
    logic [ELEM_W-1:0] t;
    n = int'(shadow_len);
    for (int i = 0; i + 1 < n; i++) begin
      m = i;
      for (int j = i + 1; j < n; j++) begin
        if (elem_less(shadow_store[j], shadow_store[m])) m = j;
      end
      if (m != i) begin
        t = shadow_store[i];
        shadow_store[i] = shadow_store[m];
        shadow_store[m] = t;
      end
    end
  endfunction

  function automatic vec_result_t apply_cmd(vec_cmd_t c);
    vec_result_t r;
    r = '0;
    case (c.opcode)
      OP_PUSH: begin
        if (shadow_len < CAPACITY) begin
          shadow_store[shadow_len[IDX_W-1:0]] = c.value;
          shadow_len = shadow_len + 1'b1;
          r.success = 1'b1;
        end
      end
      OP_SET: begin
        if (c.index < shadow_len) begin
          shadow_store[c.index] = c.value;
          r.success = 1'b1;
        end
      end
      OP_GET: begin
        if (c.index < shadow_len) begin
          r.read_value = shadow_store[c.index];
          r.success = 1'b1;
        end
      end
      OP_RESIZE: begin
        if (c.len_req != 0 && c.len_req <= CAPACITY) begin
          shadow_len = c.len_req;
          r.success = 1'b1;
        end
      end
      OP_SORT: begin
        sort_shadow();
        r.success = 1'b1;
      end
      default: ;
    endcase
    r.used_length = shadow_len;
    return r;
  endfunction

  function automatic vec_cmd_t mk_cmd(logic [OP_W-1:0] op, int unsigned idx,
                                      int unsigned val, int unsigned req);
    vec_cmd_t c;
    c.opcode  = op;
    c.index   = IDX_W'(idx);
    c.value   = ELEM_W'(val);
    c.len_req = LEN_W'(req);
    return c;
  endfunction

  // Wide random values, with extremes and small values to force ties
  function automatic int unsigned pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(ELEM_W-1){1'b0}}};
      3: return {1'b0, {(ELEM_W-1){1'b1}}};
      4, 5: return $urandom_range(0, 7) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_index();
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, 15);
    return $urandom_range(0, CAPACITY - 1);
  endfunction

  function automatic int unsigned pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 16);
    if (r < 89) return '0;
    if (r < 93) return $urandom_range(CAPACITY + 1, 127);
    return $urandom_range(17, CAPACITY);
  endfunction

  function automatic vec_cmd_t random_cmd();
    int r;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 32)      op = OP_PUSH;
    else if (r < 52) op = OP_SET;
    else if (r < 77) op = OP_GET;
    else if (r < 89) op = OP_RESIZE;
    else if (r < 97) op = OP_SORT;
    else             op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    return mk_cmd(op, pick_index(), pick_value(), pick_length());
  endfunction

  // Well-formed run: size the store, fill it, sort it, read it all back
  task automatic queue_sort_run(output int added);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
    pending_cmds.push_back(mk_cmd(OP_RESIZE, $urandom, $urandom, n));
    for (int i = 0; i < n; i++)
      pending_cmds.push_back(mk_cmd(OP_SET, i, pick_value(), $urandom));
    pending_cmds.push_back(mk_cmd(OP_SORT, $urandom, $urandom, $urandom));
    for (int i = 0; i < n; i++)
      pending_cmds.push_back(mk_cmd(OP_GET, i, $urandom, $urandom));
    added = 2 * n + 2;
  endtask

  task automatic queue_random(int count);
    int added;
    int k;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 99) < 40) begin
        queue_sort_run(k);
        added += k;
      end else begin
        pending_cmds.push_back(random_cmd());
        added++;
      end
    end
  endtask

  // Wait until every item is taken and every result has come back
  task automatic drain();
    while (pending_cmds.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_compare_mode(logic signed_mode);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= signed_mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    compare_signed_q = signed_mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sender: hold an item until taken, idle at random outside the steady stretch
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || offer_taken)) begin
      if (pending_cmds.size() != 0 &&
          ((cmds_accepted >= 250 && cmds_accepted < 350) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        offer_cmd = pending_cmds.pop_front();
        s_axis_tdata_i  <= offer_cmd;
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    offer_taken = 1'b0;
  end

  // Predict the result of each item as it is accepted
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      expected_results.push_back(apply_cmd(offer_cmd));
      offer_taken = 1'b1;
      cmds_accepted++;
    end
  end

  // Receiver: random stalls, one long hold-off, steady stretch
  always @(negedge clk_i) begin
    if (!hold_done && results_checked >= 120) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (results_checked >= 250 && results_checked < 350) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : result_check
    vec_result_t got;
    vec_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %h", got);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (got.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, got.success);
          failures++;
        end
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, got.read_value);
          failures++;
        end
        if (got.used_length !== want.used_length) begin
          $error("used_length: expected %0d, got %0d", want.used_length, got.used_length);
          failures++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) shadow_store[i] = '0;
    shadow_len       = '0;
    compare_signed_q = 1'b0;
    offer_taken      = 1'b0;
    cmds_accepted    = 0;
    results_checked  = 0;
    failures         = 0;
    hold_left        = 0;
    hold_done        = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    write_compare_mode(1'b0);
    // Directed: empty store, bad resizes, sort of short and full stores, ties
    pending_cmds.push_back(mk_cmd(OP_GET, 0, '0, '0));
    pending_cmds.push_back(mk_cmd(OP_SET, 0, '1, '0));
    pending_cmds.push_back(mk_cmd(OP_SORT, '1, '1, '1));
    pending_cmds.push_back(mk_cmd(OP_RESIZE, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_RESIZE, 0, 0, CAPACITY + 1));
    pending_cmds.push_back(mk_cmd(OP_RESIZE, '1, '1, '1));
    pending_cmds.push_back(mk_cmd(OP_PUSH, 0, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(mk_cmd(OP_SORT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_PUSH, 0, 32'h0000_0000, 0));
    pending_cmds.push_back(mk_cmd(OP_PUSH, 0, 32'h8000_0000, 0));
    pending_cmds.push_back(mk_cmd(OP_PUSH, 0, 32'h7FFF_FFFF, 0));
    pending_cmds.push_back(mk_cmd(OP_PUSH, 0, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(mk_cmd(OP_SORT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_GET, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_GET, 4, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_SET, 63, '1, '1));
    pending_cmds.push_back(mk_cmd(OP_UNUSED_FIRST, '1, '1, '1));
    pending_cmds.push_back(mk_cmd(OP_UNUSED_LAST, '1, '1, '1));
    pending_cmds.push_back(mk_cmd(OP_RESIZE, 0, 0, CAPACITY));
    pending_cmds.push_back(mk_cmd(OP_PUSH, 0, 32'h1234_5678, 0));
    pending_cmds.push_back(mk_cmd(OP_GET, 63, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_SET, 63, 32'hDEAD_BEEF, '1));
    pending_cmds.push_back(mk_cmd(OP_SORT, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_GET, 63, 0, 0));
    pending_cmds.push_back(mk_cmd(OP_RESIZE, 0, 0, 1));
    drain();

    write_compare_mode(1'b1);
    queue_random(170);
    drain();

    write_compare_mode(1'b0);
    queue_random(170);
    drain();

    write_compare_mode(1'b1);
    pending_cmds.push_back(mk_cmd(OP_RESIZE, 0, 0, CAPACITY));
    pending_cmds.push_back(mk_cmd(OP_SORT, 0, 0, 0));
    queue_random(160);
    drain();

    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bvss_pkg.sv
rtl/bvss_ram.sv
rtl/bvss_cmp.sv
rtl/bounded_vector_with_selection_sort_unit.sv
rtl/bvss_chk.sv
test/tb_top.sv
